>>> hdl/lobm_pkg.sv
`default_nettype none
package lobm_pkg;

  localparam int unsigned LOBM_DEPTH = 32;

  localparam logic [1:0] MODE_BUY    = 2'd0;
  localparam logic [1:0] MODE_SELL   = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;

  localparam logic [1:0] KIND_EXEC = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_DEL  = 2'd2;

  // One resting order.
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] rem;
    logic [31:0] exn;
  } entry_t;

  typedef enum logic [1:0] {
    BK_NONE,
    BK_REMOVE,
    BK_INSERT,
    BK_HEAD
  } bk_op_e;

  // Result of the shared compare and subtract unit.
  typedef struct packed {
    logic        lt;
    logic        eq;
    logic [31:0] diff;
  } alu_res_t;

endpackage
`default_nettype wire

>>> hdl/lobm_alu.sv
`default_nettype none
module lobm_alu import lobm_pkg::*; (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output alu_res_t    res_o
);

  logic        lt;
  logic [31:0] big;
  logic [31:0] sml;

  // The difference is always taken as larger minus smaller.
  assign lt  = a_i < b_i;
  assign big = lt ? b_i : a_i;
  assign sml = lt ? a_i : b_i;

  assign res_o.lt   = lt;
  assign res_o.eq   = a_i == b_i;
  assign res_o.diff = big - sml;

endmodule
`default_nettype wire

>>> hdl/lobm_book.sv
`default_nettype none
module lobm_book import lobm_pkg::*; #(
  parameter int unsigned BOOK_DEPTH = LOBM_DEPTH,
  localparam int unsigned IDX_W = $clog2(BOOK_DEPTH),
  localparam int unsigned CNT_W = $clog2(BOOK_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bk_op_e           op_i,
  input  logic [IDX_W-1:0] idx_i,
  input  entry_t           wr_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output entry_t           rd_o,
  output entry_t           head_o,
  output logic [CNT_W-1:0] cnt_o
);

  entry_t           ent [BOOK_DEPTH];
  logic [CNT_W-1:0] cnt_q;

  // Each entry is a shift stage: removal pulls the upper neighbor down,
  // insertion pushes the lower neighbor up.
  for (genvar j = 0; j < BOOK_DEPTH; j++) begin : g_ent
    entry_t e_q;
    entry_t up;
    entry_t dn;

    assign ent[j] = e_q;
    if (j < BOOK_DEPTH - 1) begin : g_up
      assign up = ent[j+1];
    end else begin : g_top
      assign up = e_q;
    end
    if (j > 0) begin : g_dn
      assign dn = ent[j-1];
    end else begin : g_bot
      assign dn = e_q;
    end

    always_ff @(posedge clk_i) begin
      case (op_i)
        BK_REMOVE: begin
          if (IDX_W'(j) >= idx_i) e_q <= up;
        end
        BK_INSERT: begin
          if (IDX_W'(j) == idx_i) e_q <= wr_i;
          else if (IDX_W'(j) > idx_i) e_q <= dn;
        end
        BK_HEAD: begin
          if (j == 0) e_q <= wr_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (op_i)
        BK_REMOVE: cnt_q <= cnt_q - CNT_W'(1);
        BK_INSERT: cnt_q <= cnt_q + CNT_W'(1);
        default:   ;
      endcase
    end
  end

  assign rd_o   = ent[rd_idx_i];
  assign head_o = ent[0];
  assign cnt_o  = cnt_q;

endmodule
`default_nettype wire

>>> hdl/limit_order_book_matcher_core.sv
`default_nettype none
// Channel | Direction | Signals
// --------+-----------+------------------------------------------------------
// in      | sink      | in_valid_i, in_ready_o, mode_i, order_id_i,
//         |           | instrument_i, limit_price_i, quantity_i
// out     | source    | out_valid_o, out_ready_i, kind_o, resting_order_id_o,
//         |           | incoming_order_id_o, execution_number_o, report_price_o,
//         |           | report_quantity_o, is_sell_o, accepted_o,
//         |           | instrument_echo_o, timestamp_o, last_o
//
// A command is taken only in the idle state; one transfer in, then the
// sequencer runs until its last report is loaded into the output register.
// A buy or sell walks the opposite book: each fill takes a price compare,
// then a fill through the shared compare/subtract unit. A last compare ends
// the walk; then come the rest check and a scan for the insert position.
// A cancel scans the bid book and then the ask book, one entry a cycle.
// Reset clears the book counts, the sequence counter and the output valid.
// A stalled output holds the sequencer at the step that wants to report.
module limit_order_book_matcher_core import lobm_pkg::*; #(
  parameter int unsigned BOOK_DEPTH = LOBM_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] order_id_i,
  input  logic [63:0] instrument_i,
  input  logic [31:0] limit_price_i,
  input  logic [31:0] quantity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] resting_order_id_o,
  output logic [31:0] incoming_order_id_o,
  output logic [31:0] execution_number_o,
  output logic [31:0] report_price_o,
  output logic [31:0] report_quantity_o,
  output logic        is_sell_o,
  output logic        accepted_o,
  output logic [63:0] instrument_echo_o,
  output logic [31:0] timestamp_o,
  output logic        last_o
);

  localparam int unsigned IDX_W = $clog2(BOOK_DEPTH);
  localparam int unsigned CNT_W = $clog2(BOOK_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRICE,
    ST_FILL,
    ST_REST,
    ST_POS,
    ST_CXL_BID,
    ST_CXL_ASK
  } state_e;

  // The instrument and timestamp travel with the report, so a new command
  // taken while a report waits cannot disturb it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] rid;
    logic [31:0] iid;
    logic [31:0] exn;
    logic [31:0] price;
    logic [31:0] qty;
    logic        sell;
    logic        acc;
    logic [63:0] instr;
    logic [31:0] ts;
    logic        last;
  } res_t;

  state_e           state_q, state_d;
  logic             sell_q, sell_d;
  logic [31:0]      oid_q, oid_d;
  logic [63:0]      instr_q, instr_d;
  logic [31:0]      limit_q, limit_d;
  logic [31:0]      qty_q, qty_d;
  logic [31:0]      ts_q, ts_d;
  logic [31:0]      clk_cnt_q, clk_cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  res_t             res_q, res_d, res_n;
  logic             out_valid_q, out_valid_d;

  bk_op_e           bid_op, ask_op;
  logic [IDX_W-1:0] bid_idx, ask_idx;
  entry_t           bk_wr;
  entry_t           bid_rd, ask_rd, bid_head, ask_head;
  logic [CNT_W-1:0] bid_cnt, ask_cnt;

  entry_t           opp_head, own_rd;
  logic [CNT_W-1:0] opp_cnt, own_cnt;
  logic [31:0]      alu_a, alu_b;
  alu_res_t         alu;
  logic             out_free;
  logic             emit;

  lobm_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_bid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (bid_op),
    .idx_i    (bid_idx),
    .wr_i     (bk_wr),
    .rd_idx_i (idx_q[IDX_W-1:0]),
    .rd_o     (bid_rd),
    .head_o   (bid_head),
    .cnt_o    (bid_cnt)
  );

  lobm_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_ask (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (ask_op),
    .idx_i    (ask_idx),
    .wr_i     (bk_wr),
    .rd_idx_i (idx_q[IDX_W-1:0]),
    .rd_o     (ask_rd),
    .head_o   (ask_head),
    .cnt_o    (ask_cnt)
  );

  lobm_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu)
  );

  // A sell matches against the bids and rests among the asks.
  assign opp_head = sell_q ? bid_head : ask_head;
  assign opp_cnt  = sell_q ? bid_cnt : ask_cnt;
  assign own_rd   = sell_q ? ask_rd : bid_rd;
  assign own_cnt  = sell_q ? ask_cnt : bid_cnt;
  assign out_free = !out_valid_q || out_ready_i;

  // Operand selection for the shared unit; each state that uses it picks its own operands.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      ST_PRICE: begin
        // lt means the head does not cross the limit.
        alu_a = sell_q ? opp_head.price : limit_q;
        alu_b = sell_q ? limit_q : opp_head.price;
      end
      ST_FILL: begin
        alu_a = opp_head.rem;
        alu_b = qty_q;
      end
      ST_POS: begin
        // lt means the new order goes ahead of this entry.
        alu_a = sell_q ? limit_q : own_rd.price;
        alu_b = sell_q ? own_rd.price : limit_q;
      end
      ST_CXL_BID: begin
        alu_a = bid_rd.id;
        alu_b = oid_q;
      end
      ST_CXL_ASK: begin
        alu_a = ask_rd.id;
        alu_b = oid_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    sell_d    = sell_q;
    oid_d     = oid_q;
    instr_d   = instr_q;
    limit_d   = limit_q;
    qty_d     = qty_q;
    ts_d      = ts_q;
    clk_cnt_d = clk_cnt_q;
    idx_d     = idx_q;
    bid_op    = BK_NONE;
    ask_op    = BK_NONE;
    bid_idx   = idx_q[IDX_W-1:0];
    ask_idx   = idx_q[IDX_W-1:0];
    bk_wr     = opp_head;
    emit      = 1'b0;
    res_n     = '0;
    res_n.instr = instr_q;
    res_n.ts    = ts_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (mode_i == MODE_BUY || mode_i == MODE_SELL ||
                           mode_i == MODE_CANCEL)) begin
          sell_d    = mode_i == MODE_SELL;
          oid_d     = order_id_i;
          instr_d   = instrument_i;
          limit_d   = limit_price_i;
          qty_d     = quantity_i;
          ts_d      = clk_cnt_q;
          clk_cnt_d = clk_cnt_q + 32'd1;
          idx_d     = '0;
          state_d   = (mode_i == MODE_CANCEL) ? ST_CXL_BID : ST_PRICE;
        end
      end
      ST_PRICE: begin
        if (qty_q == '0 || opp_cnt == '0 || alu.lt) state_d = ST_REST;
        else state_d = ST_FILL;
      end
      ST_FILL: begin
        if (out_free) begin
          emit        = 1'b1;
          res_n.kind  = KIND_EXEC;
          res_n.rid   = opp_head.id;
          res_n.iid   = oid_q;
          res_n.exn   = opp_head.exn;
          res_n.price = opp_head.price;
          res_n.qty   = alu.lt ? opp_head.rem : qty_q;
          res_n.acc   = 1'b1;
          res_n.last  = !alu.lt;
          bid_idx     = '0;
          ask_idx     = '0;
          bk_wr.rem   = alu.diff;
          bk_wr.exn   = opp_head.exn + 32'd1;
          if (alu.lt || alu.eq) begin
            if (sell_q) bid_op = BK_REMOVE;
            else ask_op = BK_REMOVE;
          end else begin
            if (sell_q) bid_op = BK_HEAD;
            else ask_op = BK_HEAD;
          end
          qty_d   = alu.lt ? alu.diff : '0;
          state_d = ST_PRICE;
        end
      end
      ST_REST: begin
        if (qty_q == '0) begin
          state_d = ST_IDLE;
        end else if (own_cnt == CNT_W'(BOOK_DEPTH)) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          idx_d   = '0;
          state_d = ST_POS;
        end
        res_n.kind  = KIND_ADD;
        res_n.rid   = oid_q;
        res_n.exn   = 32'd1;
        res_n.price = limit_q;
        res_n.qty   = qty_q;
        res_n.sell  = sell_q;
        res_n.last  = 1'b1;
      end
      ST_POS: begin
        res_n.kind  = KIND_ADD;
        res_n.rid   = oid_q;
        res_n.exn   = 32'd1;
        res_n.price = limit_q;
        res_n.qty   = qty_q;
        res_n.sell  = sell_q;
        res_n.acc   = 1'b1;
        res_n.last  = 1'b1;
        bk_wr.id    = oid_q;
        bk_wr.price = limit_q;
        bk_wr.rem   = qty_q;
        bk_wr.exn   = 32'd1;
        if (idx_q == own_cnt || alu.lt) begin
          if (out_free) begin
            emit = 1'b1;
            if (sell_q) ask_op = BK_INSERT;
            else bid_op = BK_INSERT;
            state_d = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_CXL_BID: begin
        res_n.kind = KIND_DEL;
        res_n.rid  = oid_q;
        res_n.acc  = 1'b1;
        res_n.last = 1'b1;
        if (idx_q == bid_cnt) begin
          idx_d   = '0;
          state_d = ST_CXL_ASK;
        end else if (alu.eq) begin
          if (out_free) begin
            emit    = 1'b1;
            bid_op  = BK_REMOVE;
            state_d = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_CXL_ASK: begin
        res_n.kind = KIND_DEL;
        res_n.rid  = oid_q;
        res_n.last = 1'b1;
        if (idx_q == ask_cnt) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (alu.eq) begin
          if (out_free) begin
            emit      = 1'b1;
            res_n.acc = 1'b1;
            ask_op    = BK_REMOVE;
            state_d   = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // The output register is reloaded only once it is free.
    res_d       = emit ? res_n : res_q;
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clk_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      clk_cnt_q   <= clk_cnt_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sell_q  <= sell_d;
    oid_q   <= oid_d;
    instr_q <= instr_d;
    limit_q <= limit_d;
    qty_q   <= qty_d;
    ts_q    <= ts_d;
    res_q   <= res_d;
  end

  assign in_ready_o          = state_q == ST_IDLE;
  assign out_valid_o         = out_valid_q;
  assign kind_o              = res_q.kind;
  assign resting_order_id_o  = res_q.rid;
  assign incoming_order_id_o = res_q.iid;
  assign execution_number_o  = res_q.exn;
  assign report_price_o      = res_q.price;
  assign report_quantity_o   = res_q.qty;
  assign is_sell_o           = res_q.sell;
  assign accepted_o          = res_q.acc;
  assign instrument_echo_o   = res_q.instr;
  assign timestamp_o         = res_q.ts;
  assign last_o              = res_q.last;

`ifndef SYNTHESIS
  a_bid_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bid_cnt <= CNT_W'(BOOK_DEPTH)) else $error("bid book over depth");
  a_ask_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ask_cnt <= CNT_W'(BOOK_DEPTH)) else $error("ask book over depth");
  a_no_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bid_op != BK_REMOVE || bid_cnt != '0) && (ask_op != BK_REMOVE || ask_cnt != '0))
    else $error("remove from empty book");
  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("report overwrote a pending result");
`endif

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lobm_pkg::*;

  // One report as seen on the output channel.
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] resting_id;
    logic [31:0] incoming_id;
    logic [31:0] exec_num;
    logic [31:0] price;
    logic [31:0] qty;
    logic        is_sell;
    logic        accepted;
    logic [63:0] instrument;
    logic [31:0] stamp;
    logic        last;
  } report_t;

  // Order book model plus the queue of reports still owed by the block.
  class book_scoreboard;
    entry_t  bids[$];
    entry_t  asks[$];
    logic [31:0] seq_count;
    report_t owed[$];
    int      errors;
    int      n_cmds;
    int      n_fills;
    int      n_adds;
    int      n_rejects;
    int      n_dels;
    int      max_bids;
    int      max_asks;

    function new();
      seq_count = '0;
      errors = 0;
      n_cmds = 0;
      n_fills = 0;
      n_adds = 0;
      n_rejects = 0;
      n_dels = 0;
      max_bids = 0;
      max_asks = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function report_t mk(logic [1:0] k, logic [31:0] rid, logic [31:0] iid,
                         logic [31:0] exn, logic [31:0] pr, logic [31:0] q,
                         logic s, logic acc, logic [63:0] ins, logic [31:0] ts);
      report_t r;
      r.kind = k;
      r.resting_id = rid;
      r.incoming_id = iid;
      r.exec_num = exn;
      r.price = pr;
      r.qty = q;
      r.is_sell = s;
      r.accepted = acc;
      r.instrument = ins;
      r.stamp = ts;
      r.last = 1'b0;
      return r;
    endfunction

    // Applies one accepted command to the books and queues its reports.
    function void note_command(logic [1:0] mode, logic [31:0] id, logic [63:0] ins,
                               logic [31:0] limit, logic [31:0] qty_in);
      report_t     batch[$];
      report_t     r;
      entry_t      opp[$];
      entry_t      own[$];
      entry_t      e;
      logic [31:0] ts;
      logic [31:0] qty;
      logic [31:0] fill;
      logic        sell;
      logic        found;
      logic        fits;
      int          pos;
      if (mode != MODE_BUY && mode != MODE_SELL && mode != MODE_CANCEL) return;
      n_cmds++;
      ts = seq_count;
      seq_count = seq_count + 1;
      qty = qty_in;
      if (mode == MODE_CANCEL) begin
        found = 1'b0;
        foreach (bids[i]) if (!found && bids[i].id == id) begin
          bids.delete(i);
          found = 1'b1;
        end
        if (!found) begin
          foreach (asks[i]) if (!found && asks[i].id == id) begin
            asks.delete(i);
            found = 1'b1;
          end
        end
        n_dels += found;
        batch.insert(batch.size(), mk(KIND_DEL, id, '0, '0, '0, '0, 1'b0, found, ins, ts));
      end else begin
        sell = (mode == MODE_SELL);
        if (sell) begin
          opp = bids;
          own = asks;
        end else begin
          opp = asks;
          own = bids;
        end
        // Walk the opposite book in priority order while prices cross.
        while (qty != 0 && opp.size() != 0) begin
          e = opp[0];
          if (sell ? (e.price < limit) : (e.price > limit)) break;
          fill = (e.rem < qty) ? e.rem : qty;
          batch.insert(batch.size(), mk(KIND_EXEC, e.id, id, e.exn, e.price, fill,
                                        1'b0, 1'b1, ins, ts));
          n_fills++;
          qty = qty - fill;
          e.rem = e.rem - fill;
          if (e.rem == 0) opp.delete(0);
          else begin
            e.exn = e.exn + 1;
            opp[0] = e;
          end
        end
        if (qty != 0) begin
          fits = own.size() < LOBM_DEPTH;
          if (fits) begin
            // Equal prices keep arrival order: go behind all of them.
            pos = 0;
            while (pos < own.size() &&
                   (sell ? (own[pos].price <= limit) : (own[pos].price >= limit))) pos++;
            e.id = id;
            e.price = limit;
            e.rem = qty;
            e.exn = 32'd1;
            own.insert(pos, e);
            n_adds++;
          end else n_rejects++;
          batch.insert(batch.size(), mk(KIND_ADD, id, '0, 32'd1, limit, qty, sell, fits,
                                        ins, ts));
        end
        if (sell) begin
          bids = opp;
          asks = own;
        end else begin
          asks = opp;
          bids = own;
        end
      end
      if (bids.size() > max_bids) max_bids = bids.size();
      if (asks.size() > max_asks) max_asks = asks.size();
      if (batch.size() > 0) begin
        r = batch[batch.size() - 1];
        r.last = 1'b1;
        batch[batch.size() - 1] = r;
      end
      foreach (batch[i]) owed.insert(owed.size(), batch[i]);
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compares one transferred report with the oldest one owed.
    function void check_report(report_t got);
      report_t w;
      if (owed.size() == 0) begin
        $error("report with nothing owed: kind %0d resting id %0h", got.kind,
               got.resting_id);
        errors++;
        return;
      end
      w = owed.pop_front();
      cmp("kind", w.kind, got.kind);
      cmp("resting_order_id", w.resting_id, got.resting_id);
      cmp("incoming_order_id", w.incoming_id, got.incoming_id);
      cmp("execution_number", w.exec_num, got.exec_num);
      cmp("report_price", w.price, got.price);
      cmp("report_quantity", w.qty, got.qty);
      cmp("is_sell", w.is_sell, got.is_sell);
      cmp("accepted", w.accepted, got.accepted);
      cmp("instrument_echo", w.instrument, got.instrument);
      cmp("timestamp", w.stamp, got.stamp);
      cmp("last", w.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  mode_i;
  logic [31:0] order_id_i;
  logic [63:0] instrument_i;
  logic [31:0] limit_price_i;
  logic [31:0] quantity_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [31:0] resting_order_id_o;
  logic [31:0] incoming_order_id_o;
  logic [31:0] execution_number_o;
  logic [31:0] report_price_o;
  logic [31:0] report_quantity_o;
  logic        is_sell_o;
  logic        accepted_o;
  logic [63:0] instrument_echo_o;
  logic [31:0] timestamp_o;
  logic        last_o;

  limit_order_book_matcher_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .mode_i              (mode_i),
    .order_id_i          (order_id_i),
    .instrument_i        (instrument_i),
    .limit_price_i       (limit_price_i),
    .quantity_i          (quantity_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .kind_o              (kind_o),
    .resting_order_id_o  (resting_order_id_o),
    .incoming_order_id_o (incoming_order_id_o),
    .execution_number_o  (execution_number_o),
    .report_price_o      (report_price_o),
    .report_quantity_o   (report_quantity_o),
    .is_sell_o           (is_sell_o),
    .accepted_o          (accepted_o),
    .instrument_echo_o   (instrument_echo_o),
    .timestamp_o         (timestamp_o),
    .last_o              (last_o)
  );

  localparam int IdleLimit = 5000;
  localparam int HoldCycles = 300;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  book_scoreboard book_sb;
  // When set, idling on both channels stops for the closing part of the run.
  bit quiet;
  // One-shot request for the receiver to hold off for a long stretch.
  bit hold_req;
  int idle_cycles;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Receiver side. The ready line changes only on the falling edge, and only
  // once per edge, so a stall burst and the long hold-off share one counter.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Output monitor: every transfer on the report channel is checked in order.
  always @(posedge clk_i) begin
    report_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind = kind_o;
      got.resting_id = resting_order_id_o;
      got.incoming_id = incoming_order_id_o;
      got.exec_num = execution_number_o;
      got.price = report_price_o;
      got.qty = report_quantity_o;
      got.is_sell = is_sell_o;
      got.accepted = accepted_o;
      got.instrument = instrument_echo_o;
      got.stamp = timestamp_o;
      got.last = last_o;
      book_sb.check_report(got);
    end
  end

  // Watchdog: any stretch without a transfer on either channel that runs past
  // the limit means the block has hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("limit_order_book_matcher_core regression: fail");
      $finish;
    end
  end

  // Offers one command and waits for its transfer. The command is handed to
  // the scoreboard at the edge where it is taken.
  task automatic send(logic [1:0] mode, logic [31:0] id, logic [63:0] ins,
                      logic [31:0] limit, logic [31:0] qty);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    order_id_i    <= id;
    instrument_i  <= ins;
    limit_price_i <= limit;
    quantity_i    <= qty;
    do @(posedge clk_i); while (!in_ready_o);
    book_sb.note_command(mode, id, ins, limit, qty);
  endtask

  // Stops offering and waits until every owed report has been transferred.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (book_sb.pending() != 0) @(posedge clk_i);
  endtask

  // Random command. Most use a narrow band of prices and a small id pool so
  // that orders cross, rest, fill partly and get cancelled by id; a few use
  // the whole range of id, price and quantity.
  task automatic send_random();
    logic [1:0]  mode;
    logic [31:0] id;
    logic [63:0] ins;
    logic [31:0] limit;
    logic [31:0] qty;
    int          pick;
    pick = $urandom_range(0, 99);
    mode = (pick < 40) ? MODE_BUY : (pick < 80) ? MODE_SELL : MODE_CANCEL;
    id = $urandom_range(1, 40);
    ins = {$urandom, $urandom};
    limit = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 260) : $urandom_range(100, 108);
    qty = $urandom_range(1, 20);
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      id = $urandom;
      limit = $urandom;
      qty = $urandom;
    end else if (pick < 10) begin
      qty = '0;
    end else if (pick < 13) begin
      mode = MODE_UNUSED;
    end
    send(mode, id, ins, limit, qty);
  endtask

  initial begin : stimulus
    int i;
    book_sb = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    idle_cycles = 0;
    in_valid_i = 1'b0;
    mode_i = MODE_BUY;
    order_id_i = '0;
    instrument_i = '0;
    limit_price_i = '0;
    quantity_i = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Two bids at one price check time priority, a bid at the
    // top price with the top quantity is swept by one large sell, and a
    // partly filled bid shows its execution number rising.
    send(MODE_BUY, 32'd1, 64'h4142_4344_4546_4748, 32'd100, 32'd10);
    send(MODE_BUY, 32'd2, 64'h4142_4344_4546_4748, 32'd100, 32'd5);
    send(MODE_BUY, 32'd3, '1, '1, '1);
    send(MODE_SELL, 32'd4, '0, 32'd100, '1);
    send(MODE_BUY, 32'd5, 64'h1, 32'd99, 32'd3);
    send(MODE_BUY, 32'd6, 64'h2, 32'd100, 32'd7);
    send(MODE_BUY, 32'd7, 64'h3, 32'd100, 32'd2);
    send(MODE_CANCEL, 32'd5, 64'h4, '0, '0);
    send(MODE_CANCEL, 32'd999, 64'h5, '1, '1);
    // The same id resting on both sides: cancels take the bid first.
    send(MODE_BUY, 32'd8, 64'h6, 32'd50, 32'd1);
    send(MODE_SELL, 32'd8, 64'h7, 32'd200, 32'd1);
    send(MODE_CANCEL, 32'd8, 64'h8, '0, '0);
    send(MODE_CANCEL, 32'd8, 64'h9, '0, '0);
    // A zero quantity still takes a timestamp; the unused mode does not.
    send(MODE_BUY, 32'd9, 64'ha, 32'd100, '0);
    send(MODE_UNUSED, '1, '1, '1, '1);
    send(MODE_SELL, 32'd10, 64'hb, '0, 32'd1);
    send(MODE_CANCEL, 32'd4, 64'hc, '0, '0);
    send(MODE_CANCEL, '1, '1, '1, '1);
    send(MODE_SELL, '1, '1, '1, 32'd1);
    send(MODE_CANCEL, '1, '0, '0, '0);

    // Fill both books past their depth so that remainders get rejected.
    for (i = 0; i < 35; i++) send(MODE_BUY, $urandom_range(1, 40), {$urandom, $urandom},
                                  $urandom_range(1, 50), $urandom_range(1, 20));
    for (i = 0; i < 35; i++) send(MODE_SELL, $urandom_range(1, 40), {$urandom, $urandom},
                                  $urandom_range(200, 250), $urandom_range(1, 20));

    // The receiver holds off while commands keep coming, so the block backs
    // up and stops taking input; afterwards the sender waits for every report.
    hold_req = 1'b1;
    for (i = 0; i < 15; i++) send_random();
    drain();

    for (i = 0; i < 155; i++) begin
      if (i == 120) quiet = 1'b1;
      send_random();
    end

    drain();
    repeat (100) @(posedge clk_i);
    $display("commands %0d: fills %0d, orders rested %0d, rejected for a full book %0d",
             book_sb.n_cmds, book_sb.n_fills, book_sb.n_adds, book_sb.n_rejects);
    $display("cancels that hit %0d; deepest bid book %0d, deepest ask book %0d",
             book_sb.n_dels, book_sb.max_bids, book_sb.max_asks);
    if (book_sb.errors == 0) begin
      $display("limit_order_book_matcher_core regression: pass");
    end else begin
      $display("limit_order_book_matcher_core regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/lobm_pkg.sv
hdl/lobm_alu.sv
hdl/lobm_book.sv
hdl/limit_order_book_matcher_core.sv
tb/sv/testbench.sv
